// ===== rtl/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared constants, types and the 5x7 font for the text glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int DEF_CHAR_ADVANCE  = 6;
    localparam int DEF_GLYPH_HEIGHT  = 7;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int CELL_COLS  = GLYPH_COLS + 1;

    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd126;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    localparam logic [15:0] FG_RESET = 16'hFFFF;
    localparam logic [15:0] BG_RESET = 16'h0000;

    // column 5 is the gap column, always background
    typedef logic [CELL_COLS-1:0][GLYPH_ROWS-1:0] t_glyph;

    typedef struct packed {
        logic                    draw;
        logic [10:0]             base_col;
        logic [15:0]             base_row;
        logic [CELL_COLS-1:0]    col_mask;
        logic [GLYPH_ROWS-1:0]   row_mask;
        logic [2:0]              last_col;
        logic [2:0]              last_row;
    } t_job;

    function automatic logic [6:0] font_index(input logic [7:0] code);
        logic [7:0] d;
        d = code - FIRST_CODE;
        if (code < FIRST_CODE || code > LAST_CODE) begin
            return 7'd0;
        end
        return d[6:0];
    endfunction

    // five column bytes, first column in the top byte
    function automatic logic [39:0] font_bytes(input logic [6:0] idx);
        logic [39:0] w;
        case (idx)
            7'd0:  w = 40'h0000000000;  7'd1:  w = 40'h00005F0000;
            7'd2:  w = 40'h0007000700;  7'd3:  w = 40'h147F147F14;
            7'd4:  w = 40'h242A7F2A12;  7'd5:  w = 40'h2313086462;
            7'd6:  w = 40'h3649552250;  7'd7:  w = 40'h0005030000;
            7'd8:  w = 40'h001C224100;  7'd9:  w = 40'h0041221C00;
            7'd10: w = 40'h082A1C2A08;  7'd11: w = 40'h08083E0808;
            7'd12: w = 40'h0050300000;  7'd13: w = 40'h0808080808;
            7'd14: w = 40'h0060600000;  7'd15: w = 40'h2010080402;
            7'd16: w = 40'h3E5149453E;  7'd17: w = 40'h00427F4000;
            7'd18: w = 40'h4261514946;  7'd19: w = 40'h2141454B31;
            7'd20: w = 40'h1814127F10;  7'd21: w = 40'h2745454539;
            7'd22: w = 40'h3C4A494930;  7'd23: w = 40'h0171090503;
            7'd24: w = 40'h3649494936;  7'd25: w = 40'h064949291E;
            7'd26: w = 40'h0036360000;  7'd27: w = 40'h0056360000;
            7'd28: w = 40'h0008142241;  7'd29: w = 40'h1414141414;
            7'd30: w = 40'h4122140800;  7'd31: w = 40'h0201510906;
            7'd32: w = 40'h324979413E;  7'd33: w = 40'h7E1111117E;
            7'd34: w = 40'h7F49494936;  7'd35: w = 40'h3E41414122;
            7'd36: w = 40'h7F4141221C;  7'd37: w = 40'h7F49494941;
            7'd38: w = 40'h7F09090101;  7'd39: w = 40'h3E41415132;
            7'd40: w = 40'h7F0808087F;  7'd41: w = 40'h00417F4100;
            7'd42: w = 40'h2040413F01;  7'd43: w = 40'h7F08142241;
            7'd44: w = 40'h7F40404040;  7'd45: w = 40'h7F0204027F;
            7'd46: w = 40'h7F0408107F;  7'd47: w = 40'h3E4141413E;
            7'd48: w = 40'h7F09090906;  7'd49: w = 40'h3E4151215E;
            7'd50: w = 40'h7F09192946;  7'd51: w = 40'h4649494931;
            7'd52: w = 40'h01017F0101;  7'd53: w = 40'h3F4040403F;
            7'd54: w = 40'h1F2040201F;  7'd55: w = 40'h7F2018207F;
            7'd56: w = 40'h6314081463;  7'd57: w = 40'h0708700807;
            7'd58: w = 40'h6151494543;  7'd59: w = 40'h007F414100;
            7'd60: w = 40'h0204081020;  7'd61: w = 40'h0041417F00;
            7'd62: w = 40'h0402010204;  7'd63: w = 40'h4040404040;
            7'd64: w = 40'h0001020400;  7'd65: w = 40'h2054545478;
            7'd66: w = 40'h7F48444438;  7'd67: w = 40'h3844444420;
            7'd68: w = 40'h384444487F;  7'd69: w = 40'h3854545418;
            7'd70: w = 40'h087E090102;  7'd71: w = 40'h081454543C;
            7'd72: w = 40'h7F08040478;  7'd73: w = 40'h00447D4000;
            7'd74: w = 40'h2040443D00;  7'd75: w = 40'h007F102844;
            7'd76: w = 40'h00417F4000;  7'd77: w = 40'h7C04180478;
            7'd78: w = 40'h7C08040478;  7'd79: w = 40'h3844444438;
            7'd80: w = 40'h7C14141408;  7'd81: w = 40'h081414187C;
            7'd82: w = 40'h7C08040408;  7'd83: w = 40'h4854545420;
            7'd84: w = 40'h043F444020;  7'd85: w = 40'h3C4040207C;
            7'd86: w = 40'h1C2040201C;  7'd87: w = 40'h3C4030403C;
            7'd88: w = 40'h4428102844;  7'd89: w = 40'h0C5050503C;
            7'd90: w = 40'h4464544C44;  7'd91: w = 40'h0008364100;
            7'd92: w = 40'h00007F0000;  7'd93: w = 40'h0041360800;
            7'd94: w = 40'h08082A1C08;
            default: w = 40'h0000000000;
        endcase
        return w;
    endfunction

    function automatic t_glyph glyph_of(input logic [6:0] idx);
        logic [39:0] w;
        t_glyph      g;
        w = font_bytes(idx);
        g = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            g[c] = w[(GLYPH_COLS-1-c)*8 +: GLYPH_ROWS];
        end
        return g;
    endfunction

endpackage

// ===== rtl/text_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_glyph_renderer
// 5x7 character generator turning a character stream into pixel writes.
// ----------------------------------------------------------------------------
// A printable character is accepted, then the cell scanner steps
// through the 6x7 cell (five glyph columns plus a gap column) one position per
// cycle up to the last on-screen pixel; no new character is accepted until
// the scan is done. Output stalls hold the scanner. A newline or a fully
// clipped character starts no scan and writes nothing. The user must write
// colors on the config port only while the block is idle; the block itself
// does not enforce this.
module text_glyph_renderer import tgr_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int CHAR_ADVANCE  = DEF_CHAR_ADVANCE,
    parameter int GLYPH_HEIGHT  = DEF_GLYPH_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // start_col, start_row, char_code
    input  logic        i_s_axis_tuser,   // start_flag
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // pixel_col, pixel_row, pixel_color
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0] r_fg, r_bg;
    logic        accept, busy;
    t_job        job;
    logic [8:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [15:0] pixel_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FOREGROUND: r_fg <= i_cfg_wdata;
                REG_BACKGROUND: r_bg <= i_cfg_wdata;
                default:        r_fg <= r_fg;
            endcase
        end
    end

    assign o_s_axis_tready = !busy;
    assign accept          = i_s_axis_tvalid && !busy;

    tgr_cursor #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CHAR_ADVANCE  (CHAR_ADVANCE),
        .GLYPH_HEIGHT  (GLYPH_HEIGHT)
    ) u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_start_flag (i_s_axis_tuser),
        .i_start_col  (i_s_axis_tdata[9:0]),
        .i_start_row  (i_s_axis_tdata[19:10]),
        .i_char_code  (i_s_axis_tdata[27:20]),
        .o_job        (job)
    );

    tgr_raster u_raster (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept && job.draw),
        .i_char_code   (i_s_axis_tdata[27:20]),
        .i_job         (job),
        .i_fg_color    (r_fg),
        .i_bg_color    (r_bg),
        .i_out_ready   (i_m_axis_tready),
        .o_busy        (busy),
        .o_out_valid   (o_m_axis_tvalid),
        .o_pixel_col   (pixel_col),
        .o_pixel_row   (pixel_row),
        .o_pixel_color (pixel_color),
        .o_last_pixel  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, pixel_color, pixel_row, pixel_col};

endmodule

// ===== rtl/tgr_cursor.sv =====
// ----------------------------------------------------------------------------
// tgr_cursor
// Cursor and margin state; builds the clip masks for each character cell.
// ----------------------------------------------------------------------------
module tgr_cursor import tgr_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int CHAR_ADVANCE  = DEF_CHAR_ADVANCE,
    parameter int GLYPH_HEIGHT  = DEF_GLYPH_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_start_flag,
    input  logic [9:0] i_start_col,
    input  logic [9:0] i_start_row,
    input  logic [7:0] i_char_code,
    output t_job       o_job
);

    localparam logic [15:0] LINE_STEP = 16'(GLYPH_HEIGHT + 1);
    localparam logic [10:0] ADV       = 11'(CHAR_ADVANCE);
    localparam logic [11:0] WIDTH     = 12'(SCREEN_WIDTH);
    localparam logic [15:0] HEIGHT    = 16'(SCREEN_HEIGHT);

    logic [9:0]  r_margin, n_margin;
    logic [10:0] r_col,    n_col;
    logic [15:0] r_row,    n_row;

    logic [10:0] eff_col, adv_col;
    logic [15:0] eff_row;
    logic [9:0]  eff_margin;
    logic        newline, wrap;
    t_job        job;

    always_comb begin
        eff_margin = i_start_flag ? i_start_col : r_margin;
        eff_col    = i_start_flag ? {1'b0, i_start_col} : r_col;
        eff_row    = i_start_flag ? {6'd0, i_start_row} : r_row;
        newline    = (i_char_code == NEWLINE_CODE);
        adv_col    = eff_col + ADV;
        wrap       = ({1'b0, adv_col} + {1'b0, ADV}) > WIDTH;

        n_margin = eff_margin;
        if (newline || wrap) begin
            n_col = {1'b0, eff_margin};
            n_row = eff_row + LINE_STEP;
        end else begin
            n_col = adv_col;
            n_row = eff_row;
        end

        job          = '0;
        job.base_col = eff_col;
        job.base_row = eff_row;
        for (int c = 0; c < CELL_COLS; c++) begin
            job.col_mask[c] = ({1'b0, eff_col} + 12'(c)) < WIDTH;
            if (job.col_mask[c]) begin
                job.last_col = 3'(c);
            end
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            job.row_mask[r] = (eff_row + 16'(r)) < HEIGHT;
            if (job.row_mask[r]) begin
                job.last_row = 3'(r);
            end
        end
        job.draw = !newline && (job.col_mask != '0) && (job.row_mask != '0);
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_accept) begin
            r_margin <= n_margin;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

// ===== rtl/tgr_raster.sv =====
// ----------------------------------------------------------------------------
// tgr_raster
// Glyph ROM and cell scanner: walks the 6x7 cell column-major, one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
module tgr_raster import tgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_char_code,
    input  t_job        i_job,
    input  logic [15:0] i_fg_color,
    input  logic [15:0] i_bg_color,
    input  logic        i_out_ready,
    output logic        o_busy,
    output logic        o_out_valid,
    output logic [8:0]  o_pixel_col,
    output logic [7:0]  o_pixel_row,
    output logic [15:0] o_pixel_color,
    output logic        o_last_pixel
);

    typedef enum logic {ST_IDLE, ST_DRAW} t_state;

    t_state      r_state;
    t_job        r_job;
    t_glyph      r_glyph;
    logic [2:0]  r_col, r_row;
    logic        r_out_valid, r_out_last;
    logic [8:0]  r_out_col;
    logic [7:0]  r_out_row;
    logic [15:0] r_out_color;

    logic        step, vis, at_last;
    logic [10:0] pix_col;
    logic [15:0] pix_row;

    // synchronous font ROM, read when a character is started
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_glyph <= glyph_of(font_index(i_char_code));
        end
    end

    always_comb begin
        step    = (r_state == ST_DRAW) && (!r_out_valid || i_out_ready);
        vis     = r_job.col_mask[r_col] && r_job.row_mask[r_row];
        at_last = (r_col == r_job.last_col) && (r_row == r_job.last_row);
        pix_col = r_job.base_col + 11'(r_col);
        pix_row = r_job.base_row + 16'(r_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_out_ready && !step) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_job   <= i_job;
                        r_col   <= '0;
                        r_row   <= '0;
                        r_state <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    if (step) begin
                        r_out_valid <= vis;
                        r_out_last  <= at_last;
                        r_out_col   <= pix_col[8:0];
                        r_out_row   <= pix_row[7:0];
                        r_out_color <= r_glyph[r_col][r_row] ? i_fg_color : i_bg_color;
                        if (at_last) begin
                            r_state <= ST_IDLE;
                        end else if (r_row == 3'(GLYPH_ROWS - 1)) begin
                            r_row <= '0;
                            r_col <= r_col + 3'd1;
                        end else begin
                            r_row <= r_row + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_col   = r_out_col;
    assign o_pixel_row   = r_out_row;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("character started while scan busy");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (r_col <= r_job.last_col && r_row <= 3'(GLYPH_ROWS - 1)))
        else $error("scan ran past the last visible column");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && at_last) |=> (r_state == ST_IDLE && r_out_valid && r_out_last))
        else $error("final cell did not produce a last pixel");

endmodule
